>>> hw/rtl/mmp_pkg.sv
// Shared constants, types and helpers for the Markov matrix power row block.
package mmp_pkg;

  localparam int unsigned MAX_STATES_DEF = 64;

  localparam int unsigned PROB_W = 32;
  localparam int unsigned NS_W   = 7;
  localparam int unsigned POW_W  = 16;
  localparam int unsigned SS_W   = 6;
  localparam int unsigned TS_W   = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd2;

  localparam logic [NS_W-1:0]  NUM_STATES_RST  = 7'd40;
  localparam logic [POW_W-1:0] POWER_RST       = 16'd2500;
  localparam logic [SS_W-1:0]  START_STATE_RST = 6'd0;

  localparam logic [PROB_W-1:0] ONE_Q31 = 32'h8000_0000;

  // controller -> datapath
  typedef struct packed {
    logic cfg_write;
    logic load;
    logic div_start;
    logic div_step;
    logic copy_init;
    logic copy_issue;
    logic mac_issue;
    logic mac_done;
    logic emit_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_last;
    logic div_last;
    logic k_last;
    logic col_last;
    logic pipe_idle;
    logic rem_zero;
    logic rem_one;
    logic out_free;
  } status_t;

  // dimension in use: zero acts as one, clamp at the array size
  function automatic int unsigned dim_in_use(input logic [NS_W-1:0] ns,
                                             input int unsigned max_states);
    int unsigned d;
    d = 32'(ns);
    if (d == 0) d = 1;
    if (d > max_states) d = max_states;
    return d;
  endfunction

endpackage

>>> hw/rtl/mmp_datapath.sv
// Datapath: config registers, matrix and row memories, MAC pipeline, load divider, output register.
module mmp_datapath #(
  parameter int unsigned MAX_STATES = mmp_pkg::MAX_STATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mmp_pkg::PROB_W-1:0]        probability,
  input  logic                              out_ready,
  input  mmp_pkg::cmd_t                     cmd,
  output mmp_pkg::status_t                  status,
  output logic                              out_valid,
  output logic [mmp_pkg::TS_W-1:0]          target_state,
  output logic [mmp_pkg::PROB_W-1:0]        result_prob,
  output logic                              last_result
);

  localparam int unsigned IW       = $clog2(MAX_STATES);
  localparam int unsigned NW       = $clog2(MAX_STATES + 1);
  localparam int unsigned LC_W     = $clog2(MAX_STATES * MAX_STATES + 1);
  localparam int unsigned DC_W     = $clog2(LC_W + 1);
  localparam int unsigned PW       = mmp_pkg::PROB_W;
  localparam int unsigned ACC_W    = 2 * PW + IW;
  localparam int unsigned ACC_Q_W  = ACC_W - (PW - 1);
  localparam int unsigned ST_DEPTH = 1 << (2 * IW);
  localparam int unsigned RM_DEPTH = 1 << (IW + 1);

  // configuration
  logic [mmp_pkg::NS_W-1:0]  num_states;
  logic [mmp_pkg::POW_W-1:0] power;
  logic [mmp_pkg::SS_W-1:0]  start_state;

  logic [NW-1:0]   n;
  logic [NW-1:0]   n_m1;
  logic [LC_W-1:0] nn;
  logic [IW-1:0]   s_row;

  // loop counters
  logic [IW-1:0]   k;
  logic [IW-1:0]   col;
  logic            k_last;
  logic            col_last;
  logic [mmp_pkg::POW_W-1:0] step_rem;
  logic            bank;

  // load position
  logic [LC_W-1:0] lc;
  logic [LC_W-1:0] lc_inc;
  logic [LC_W-1:0] ld_row;
  logic [IW-1:0]   ld_col;
  logic            load_last;

  // restoring divider for load position after a dimension change
  logic [DC_W-1:0] div_cnt;
  logic [NW-1:0]   div_rem;
  logic [LC_W-1:0] div_quo;
  logic [NW:0]     rem_sh;
  logic            rem_ge;
  logic [NW:0]     rem_nx;
  logic [LC_W-1:0] quo_nx;
  logic            div_last;

  // memories
  logic [PW-1:0]     store [ST_DEPTH];
  logic [PW-1:0]     store_rd;
  logic              store_we;
  logic [2*IW-1:0]   store_waddr;
  logic [2*IW-1:0]   store_raddr;
  logic [PW-1:0]     load_p;

  logic [PW-1:0]     row_mem [RM_DEPTH];
  logic [PW-1:0]     row_rd;
  logic              row_we;
  logic [IW:0]       row_waddr;
  logic [IW:0]       row_raddr;
  logic [PW-1:0]     row_wdata;

  // pipeline
  logic              c1_v;
  logic [IW-1:0]     c1_idx;
  logic              m1_v, m1_first, m1_last;
  logic [IW-1:0]     m1_col;
  logic              m2_v, m2_first, m2_last;
  logic [IW-1:0]     m2_col;
  logic              m3_v;
  logic [IW-1:0]     m3_col;
  logic [2*PW-1:0]   prod;
  logic [ACC_W-1:0]  acc;
  logic [ACC_Q_W-1:0] acc_q;
  logic [PW-1:0]     sat_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= mmp_pkg::NUM_STATES_RST;
      power       <= mmp_pkg::POWER_RST;
      start_state <= mmp_pkg::START_STATE_RST;
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        mmp_pkg::CFG_NUM_STATES:  num_states  <= cfg_data[mmp_pkg::NS_W-1:0];
        mmp_pkg::CFG_POWER:       power       <= cfg_data[mmp_pkg::POW_W-1:0];
        mmp_pkg::CFG_START_STATE: start_state <= cfg_data[mmp_pkg::SS_W-1:0];
        default: ;
      endcase
    end
  end

  assign n    = NW'(mmp_pkg::dim_in_use(num_states, MAX_STATES));
  assign n_m1 = n - NW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      nn <= LC_W'(mmp_pkg::dim_in_use(mmp_pkg::NUM_STATES_RST, MAX_STATES) *
                  mmp_pkg::dim_in_use(mmp_pkg::NUM_STATES_RST, MAX_STATES));
    end else begin
      nn <= LC_W'(n) * LC_W'(n);
    end
  end

  always_comb begin
    if (int'(start_state) >= int'(n)) begin
      s_row = IW'(n_m1);
    end else begin
      s_row = IW'(start_state);
    end
  end

  assign k_last   = (NW'(k) == n_m1);
  assign col_last = (NW'(col) == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      col      <= '0;
      bank     <= 1'b0;
      step_rem <= '0;
    end else begin
      if (cmd.copy_issue || cmd.mac_issue || cmd.emit_load) begin
        k <= k_last ? '0 : k + IW'(1);
      end
      if (cmd.mac_issue && k_last) begin
        col <= col_last ? '0 : col + IW'(1);
      end
      if (cmd.copy_init) begin
        step_rem <= (power == '0) ? '0 : power - mmp_pkg::POW_W'(1);
      end else if (cmd.mac_done) begin
        step_rem <= step_rem - mmp_pkg::POW_W'(1);
      end
      if (cmd.mac_done) begin
        bank <= ~bank;
      end
    end
  end

  // load counting and divider
  assign lc_inc    = lc + LC_W'(1);
  assign load_last = (lc_inc >= nn);
  assign rem_sh    = {div_rem, div_quo[LC_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, n});
  assign rem_nx    = rem_ge ? rem_sh - {1'b0, n} : rem_sh;
  assign quo_nx    = {div_quo[LC_W-2:0], rem_ge};
  assign div_last  = (div_cnt == DC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lc      <= '0;
      ld_row  <= '0;
      ld_col  <= '0;
      div_cnt <= '0;
    end else if (cmd.load) begin
      if (load_last) begin
        lc     <= '0;
        ld_row <= '0;
        ld_col <= '0;
      end else begin
        lc <= lc_inc;
        if (NW'(ld_col) == n_m1) begin
          ld_col <= '0;
          ld_row <= ld_row + LC_W'(1);
        end else begin
          ld_col <= ld_col + IW'(1);
        end
      end
    end else if (cmd.div_start) begin
      div_cnt <= DC_W'(LC_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DC_W'(1);
      if (div_last) begin
        ld_row <= quo_nx;
        ld_col <= IW'(rem_nx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_quo <= lc;
    end else if (cmd.div_step) begin
      div_rem <= rem_nx[NW-1:0];
      div_quo <= quo_nx;
    end
  end

  // transition matrix store
  assign load_p      = (probability > mmp_pkg::ONE_Q31) ? mmp_pkg::ONE_Q31 : probability;
  assign store_we    = cmd.load && (ld_row < LC_W'(n));
  assign store_waddr = {ld_row[IW-1:0], ld_col};
  assign store_raddr = cmd.copy_issue ? {s_row, k} : {k, col};

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_waddr] <= load_p;
    end
    store_rd <= store[store_raddr];
  end

  // ping-pong row buffer: current row in bank, next row in ~bank
  assign acc_q     = acc[ACC_W-1:PW-1];
  assign sat_acc   = (acc_q > ACC_Q_W'(mmp_pkg::ONE_Q31)) ? mmp_pkg::ONE_Q31 : acc_q[PW-1:0];
  assign row_raddr = {bank, k};
  assign row_we    = c1_v || m3_v;
  assign row_waddr = c1_v ? {bank, c1_idx} : {~bank, m3_col};
  assign row_wdata = c1_v ? store_rd : sat_acc;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd <= row_mem[row_raddr];
  end

  // MAC pipeline: read, multiply, accumulate, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
    end else begin
      c1_v <= cmd.copy_issue;
      m1_v <= cmd.mac_issue;
      m2_v <= m1_v;
      m3_v <= m2_v && m2_last;
    end
  end

  always_ff @(posedge clk) begin
    c1_idx   <= k;
    m1_first <= (k == '0);
    m1_last  <= k_last;
    m1_col   <= col;
    m2_first <= m1_first;
    m2_last  <= m1_last;
    m2_col   <= m1_col;
    m3_col   <= m2_col;
    prod     <= (2*PW)'(store_rd) * (2*PW)'(row_rd);
    if (m2_v) begin
      acc <= (m2_first ? '0 : acc) + ACC_W'(prod);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      result_prob  <= row_rd;
      target_state <= mmp_pkg::TS_W'(k);
      last_result  <= k_last;
    end
  end

  always_comb begin
    status.load_last = load_last;
    status.div_last  = div_last;
    status.k_last    = k_last;
    status.col_last  = col_last;
    status.pipe_idle = !(c1_v || m1_v || m2_v || m3_v);
    status.rem_zero  = (step_rem == '0);
    status.rem_one   = (step_rem == mmp_pkg::POW_W'(1));
    status.out_free  = !out_valid || out_ready;
  end

  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_prob <= mmp_pkg::ONE_Q31))
    else $error("result above 1.0");

  a_row_port: assert property (@(posedge clk) disable iff (rst)
    !(c1_v && m3_v))
    else $error("copy and MAC write the row buffer together");

  a_wb_order: assert property (@(posedge clk) disable iff (rst)
    m3_v |-> $past(m2_v && m2_last))
    else $error("write-back without a final accumulate");

endmodule

>>> hw/rtl/mmp_ctrl.sv
// Controller: sequences load, divide, copy, MAC steps and result emission.
module mmp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          cfg_valid,
  input  logic [mmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  mmp_pkg::status_t              status,
  output logic                          in_ready,
  output logic                          cfg_ready,
  output mmp_pkg::cmd_t                 cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_COPY    = 3'd2;
  localparam logic [2:0] S_CDRAIN  = 3'd3;
  localparam logic [2:0] S_MAC     = 3'd4;
  localparam logic [2:0] S_MDRAIN  = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_LD = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // config takes priority over a load in the same cycle
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (cfg_index == mmp_pkg::CFG_NUM_STATES) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else if (in_valid) begin
          cmd.load = 1'b1;
          if (status.load_last) begin
            cmd.copy_init = 1'b1;
            state_next    = S_COPY;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_IDLE;
      end
      S_COPY: begin
        cmd.copy_issue = 1'b1;
        if (status.k_last) state_next = S_CDRAIN;
      end
      S_CDRAIN: begin
        if (status.pipe_idle) begin
          state_next = status.rem_zero ? S_EMIT_RD : S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.k_last && status.col_last) state_next = S_MDRAIN;
      end
      S_MDRAIN: begin
        if (status.pipe_idle) begin
          cmd.mac_done = 1'b1;
          state_next   = status.rem_one ? S_EMIT_RD : S_MAC;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = status.k_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> status.out_free)
    else $error("output register overwritten");

  a_step_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDRAIN && status.pipe_idle) |=> (state == S_MAC || state == S_EMIT_RD))
    else $error("bad exit from step drain");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> status.pipe_idle)
    else $error("load while the pipeline is busy");

endmodule

>>> hw/rtl/markov_matrix_power_row.sv
// Top level of the Markov transition matrix power row block.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 num_states,
//   1 power, 2 start_state. Accepted only while the block is idle. A write to
//   num_states starts a restoring divide that rebuilds the load position;
//   no entry is taken during it.
//   in channel (in_valid/in_ready, probability): one matrix entry per cycle
//   while idle and cfg_valid is low, row-major. Entries above 1.0 are stored
//   as 1.0. After the n*n-th entry: copy of the start row, then K-1
//   row-by-matrix steps, all on one 32x32 multiply-accumulate unit; then n
//   results, each read from the row buffer and then loaded for output.
//   out channel (out_valid/out_ready, target_state, result_prob,
//   last_result): one transaction per column, last_result on the final one.
//   The output register holds a result while the receiver stalls; the
//   sequencer waits on it, and the next load may start while the last
//   result of a row is still waiting.
//   Reset (rst, synchronous) restores num_states 40, power 2500, start 0 and
//   clears the load position; matrix memories are not cleared.
module markov_matrix_power_row #(
  parameter int unsigned MAX_STATES = mmp_pkg::MAX_STATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mmp_pkg::PROB_W-1:0]        probability,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mmp_pkg::TS_W-1:0]          target_state,
  output logic [mmp_pkg::PROB_W-1:0]        result_prob,
  output logic                              last_result
);

  mmp_pkg::cmd_t    cmd;
  mmp_pkg::status_t status;

  mmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .status    (status),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  mmp_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .probability  (probability),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .target_state (target_state),
    .result_prob  (result_prob),
    .last_result  (last_result)
  );

endmodule

>>> test/markov_matrix_power_row_test.sv
// Self-checking testbench for the Markov matrix power row block.
module markov_matrix_power_row_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM        = mmp_pkg::MAX_STATES_DEF;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned HOLD_LEN       = 400;
  localparam int unsigned WATCHDOG_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS    = 70;
  localparam int unsigned WIDE_ITEMS     = 66;
  // index 3 is not a register; writes to it must be ignored
  localparam logic [mmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [mmp_pkg::CFG_IDX_W-1:0]  index;
    logic [mmp_pkg::CFG_DATA_W-1:0] data;
    logic [mmp_pkg::PROB_W-1:0]     prob;
    bit                             typed;
    logic [mmp_pkg::PROB_W-1:0]     want;
  } stim_row_t;

  typedef struct packed {
    logic [mmp_pkg::TS_W-1:0]   target;
    logic [mmp_pkg::PROB_W-1:0] prob;
    logic                       last;
  } row_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mmp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mmp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mmp_pkg::PROB_W-1:0]     probability = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mmp_pkg::TS_W-1:0]       target_state;
  logic [mmp_pkg::PROB_W-1:0]     result_prob;
  logic                           last_result;

  // shadow of the block: registers, matrix store, load position
  bit [mmp_pkg::NS_W-1:0]   dim_reg;
  bit [mmp_pkg::POW_W-1:0]  power_reg;
  bit [mmp_pkg::SS_W-1:0]   start_reg;
  bit [mmp_pkg::PROB_W-1:0] trans_mat [MAX_DIM*MAX_DIM];
  int unsigned              load_pos;

  row_result_t row_results_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned results_checked = 0;
  int unsigned rows_done = 0;

  stim_row_t directed_rows [32] = '{
    '{ROW_CFG,  mmp_pkg::CFG_NUM_STATES,  16'd1,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_POWER,       16'd0,    32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h8000_0001, 1'b1, 32'h8000_0000},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h0000_0001, 1'b1, 32'h0000_0001},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h5555_5555, 1'b1, 32'h5555_5555},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'hAAAA_AAAA, 1'b1, 32'h8000_0000},
    // dimension zero behaves as one
    '{ROW_CFG,  mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_POWER,       16'd1,    32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h4000_0000, 1'b1, 32'h4000_0000},
    // largest exponent on a 1x1 chain, 1.0 stays 1.0
    '{ROW_CFG,  mmp_pkg::CFG_POWER,       16'hFFFF, 32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    // start row past the dimension selects the last row
    '{ROW_CFG,  mmp_pkg::CFG_NUM_STATES,  16'd2,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_POWER,       16'd3,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_START_STATE, 16'h003F, 32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h4000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h4000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h2000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h6000_0000, 1'b0, 32'h0},
    '{ROW_CFG,  CFG_UNUSED,               16'hFFFF, 32'h0,         1'b0, 32'h0},
    // shrink the dimension in the middle of a load
    '{ROW_CFG,  mmp_pkg::CFG_NUM_STATES,  16'd3,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_POWER,       16'd1,    32'h0,         1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_START_STATE, 16'd0,    32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h1000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h3000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h4000_0000, 1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_CFG,  mmp_pkg::CFG_NUM_STATES,  16'd2,    32'h0,         1'b0, 32'h0},
    '{ROW_ITEM, mmp_pkg::CFG_NUM_STATES,  16'd0,    32'h1234_5678, 1'b0, 32'h0}
  };

  markov_matrix_power_row DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .probability  (probability),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .target_state (target_state),
    .result_prob  (result_prob),
    .last_result  (last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned active_dim();
    int unsigned n;
    n = 32'(dim_reg);
    if (n == 0) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  function automatic void apply_reg(input logic [mmp_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mmp_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      mmp_pkg::CFG_NUM_STATES:  dim_reg = d[mmp_pkg::NS_W-1:0];
      mmp_pkg::CFG_POWER:       power_reg = d[mmp_pkg::POW_W-1:0];
      mmp_pkg::CFG_START_STATE: start_reg = d[mmp_pkg::SS_W-1:0];
      default: ;
    endcase
  endfunction

  // Row s of P^K: start from row s, then K-1 row-by-matrix products.
  function automatic void raise_row_to_power();
    int unsigned n, s, steps;
    bit [mmp_pkg::PROB_W-1:0] cur [MAX_DIM];
    bit [mmp_pkg::PROB_W-1:0] nxt [MAX_DIM];
    bit [63:0] prod, whole, frac, total;
    row_result_t r;
    n = active_dim();
    s = 32'(start_reg);
    if (s >= n) s = n - 1;
    steps = (power_reg == 0) ? 1 : 32'(power_reg);
    for (int unsigned k = 0; k < n; k++) cur[k] = trans_mat[s*MAX_DIM + k];
    for (int unsigned st = 1; st < steps; st++) begin
      for (int unsigned col = 0; col < n; col++) begin
        whole = '0;
        frac = '0;
        for (int unsigned k = 0; k < n; k++) begin
          prod = 64'(cur[k]) * 64'(trans_mat[k*MAX_DIM + col]);
          whole += prod >> 31;
          frac += prod & 64'h7FFF_FFFF;
        end
        total = whole + (frac >> 31);
        nxt[col] = (total > 64'(mmp_pkg::ONE_Q31)) ? mmp_pkg::ONE_Q31
                                                    : total[mmp_pkg::PROB_W-1:0];
      end
      for (int unsigned col = 0; col < n; col++) cur[col] = nxt[col];
    end
    for (int unsigned k = 0; k < n; k++) begin
      r.target = k[mmp_pkg::TS_W-1:0];
      r.prob = cur[k];
      r.last = (k == n - 1);
      row_results_due.push_back(r);
    end
  endfunction

  function automatic void absorb_entry(input logic [mmp_pkg::PROB_W-1:0] p);
    int unsigned n, row, col;
    bit [mmp_pkg::PROB_W-1:0] v;
    n = active_dim();
    row = load_pos / n;
    col = load_pos % n;
    v = (p > mmp_pkg::ONE_Q31) ? mmp_pkg::ONE_Q31 : p;
    if (row < n) trans_mat[row*MAX_DIM + col] = v;
    load_pos++;
    if (load_pos >= n * n) begin
      load_pos = 0;
      raise_row_to_power();
      rows_done++;
    end
  endfunction

  // All tasks below are entered and left at a falling edge.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (row_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmp_pkg::CFG_DATA_W-1:0] d);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [mmp_pkg::PROB_W-1:0] p, input bit typed,
                           input logic [mmp_pkg::PROB_W-1:0] want);
    row_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      probability <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    probability <= p;
    do @(posedge clk); while (!in_ready);
    absorb_entry(p);
    if (typed) begin
      r = row_results_due.pop_back();
      r.prob = want;
      row_results_due.push_back(r);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic randomize_regs();
    logic [mmp_pkg::CFG_DATA_W-1:0] d;
    d = mmp_pkg::CFG_DATA_W'($urandom);
    d[mmp_pkg::NS_W-1:0] = mmp_pkg::NS_W'($urandom_range(0, 6));
    write_reg(mmp_pkg::CFG_NUM_STATES, d);
    d = mmp_pkg::CFG_DATA_W'($urandom_range(0, 7));
    write_reg(mmp_pkg::CFG_POWER, d);
    d = mmp_pkg::CFG_DATA_W'($urandom);
    write_reg(mmp_pkg::CFG_START_STATE, d);
  endtask

  // Mostly sub-stochastic rows with random content, some raw noise.
  task automatic load_matrix(input bit noisy);
    int unsigned n;
    logic [mmp_pkg::PROB_W-1:0] p;
    n = active_dim();
    for (int unsigned i = 0; i < n * n; i++) begin
      if (noisy ? ($urandom_range(3) == 0) : ($urandom_range(9) == 0))
        p = $urandom;
      else if (noisy)
        p = $urandom_range(0, mmp_pkg::ONE_Q31);
      else
        p = $urandom_range(0, mmp_pkg::ONE_Q31 / n);
      send_item(p, 1'b0, '0);
    end
  endtask

  initial begin : recv_side
    int unsigned hold_left, pct;
    hold_left = 0;
    pct = 0;
    forever begin
      @(posedge clk);
      pct = recv_idle_pct;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    row_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (row_results_due.size() == 0) begin
        $error("unexpected result: target_state %0d result_prob %h last_result %b",
               target_state, result_prob, last_result);
        error_count++;
      end else begin
        exp_r = row_results_due.pop_front();
        if (target_state !== exp_r.target) begin
          $error("target_state: expected %0d, actual %0d", exp_r.target, target_state);
          error_count++;
        end
        if (result_prob !== exp_r.prob) begin
          $error("result_prob: expected %h, actual %h", exp_r.prob, result_prob);
          error_count++;
        end
        if (last_result !== exp_r.last) begin
          $error("last_result: expected %b, actual %b", exp_r.last, last_result);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    int unsigned quota, mats;
    bit hold_done, pause_done;
    send_pct = '{37, 48, 0};
    recv_pct = '{48, 37, 0};
    hold_done = 1'b0;
    pause_done = 1'b0;
    mats = 0;
    dim_reg = mmp_pkg::NUM_STATES_RST;
    power_reg = mmp_pkg::POWER_RST;
    start_reg = mmp_pkg::START_STATE_RST;
    load_pos = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].index, directed_rows[i].data);
      else
        send_item(directed_rows[i].prob, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        if (mats == 0 || $urandom_range(2) == 0) randomize_regs();
        if (ph == 1 && !hold_done) begin
          // output blocked while the next matrices keep arriving
          write_reg(mmp_pkg::CFG_NUM_STATES, 16'd3);
          write_reg(mmp_pkg::CFG_POWER, 16'd2);
          hold_req = 1'b1;
          hold_done = 1'b1;
          load_matrix(1'b0);
          load_matrix(1'b0);
          mats += 2;
        end
        if (ph == 0 && mats == 3 && !pause_done) begin
          wait_for_results();
          pause_done = 1'b1;
        end
        load_matrix($urandom_range(3) == 0);
        mats++;
      end
    end

    // dimension above the maximum clamps to 64: the first entries fill row 0
    // and the start of row 1, then a shrink to 2 closes the load
    write_reg(mmp_pkg::CFG_NUM_STATES, 16'd127);
    for (int unsigned i = 0; i < WIDE_ITEMS; i++)
      send_item($urandom_range(0, mmp_pkg::ONE_Q31), 1'b0, '0);
    write_reg(mmp_pkg::CFG_NUM_STATES, 16'd2);
    write_reg(mmp_pkg::CFG_POWER, 16'd2);
    write_reg(mmp_pkg::CFG_START_STATE, 16'd1);
    send_item(32'h0BAD_F00D, 1'b0, '0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d matrix entries and %0d register writes, checked %0d results of %0d rows",
             items_sent, cfg_writes, results_checked, rows_done);
    $display("covered dimensions 0 to 127, powers 0 to 65535, three idle mixes, one long stall");
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
